// ----- rtl/hbc_pkg.sv -----
// shared types, codes and codeword functions for the byte-stream hamming codec
`default_nettype none

package hbc_pkg;

  // operation codes of an input item
  localparam logic OP_DATA = 1'b0;
  localparam logic OP_END  = 1'b1;

  // mode register values
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // status codes of a result item
  localparam logic [1:0] ST_DATA     = 2'd0;
  localparam logic [1:0] ST_END_OK   = 2'd1;
  localparam logic [1:0] ST_BAD_WORD = 2'd2;

  localparam int WORD_W      = 40;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  // bytes per block in each mode
  localparam logic [2:0] ENC_BLOCK = 3'd4;
  localparam logic [2:0] DEC_BLOCK = 3'd5;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last_of_run;
  } out_item_t;

  // one unit of output work: bytes from the top of word, then an optional status
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [2:0]        nbytes;
    logic [1:0]        status;
  } job_t;

  // place data bits at non power-of-two positions, then fill the parity positions
  function automatic logic [WORD_W-1:0] encode_word(input logic [DATA_W-1:0] data);
    logic [WORD_W-1:0] w;
    logic              par;
    int                j;
    w = '0;
    j = DATA_W;
    for (int p = 1; p <= 38; p++) begin
      if ((p & (p - 1)) != 0) begin
        j = j - 1;
        w[39 - p] = data[j];
      end
    end
    for (int b = 0; b < 6; b++) begin
      par = 1'b0;
      for (int q = 1; q <= 39; q++) begin
        if ((q & (1 << b)) != 0) par = par ^ w[39 - q];
      end
      w[39 - (1 << b)] = par;
    end
    return w;
  endfunction

  // pull the data bits back out of a codeword, no checking
  function automatic logic [DATA_W-1:0] decode_word(input logic [WORD_W-1:0] w);
    logic [DATA_W-1:0] d;
    int                j;
    d = '0;
    j = DATA_W;
    for (int p = 1; p <= 38; p++) begin
      if ((p & (p - 1)) != 0) begin
        j = j - 1;
        d[j] = w[39 - p];
      end
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/hbc_front.sv -----
// front end: gathers bytes into blocks and turns finished blocks and ends into jobs
`default_nettype none

module hbc_front
  import hbc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_item,
  input  wire logic     q_full,
  output logic          push,
  output job_t          push_job
);

  logic              mode;
  logic [2:0]        byte_count;
  logic [WORD_W-1:0] gathered_word;

  logic              accept;
  logic [2:0]        block;
  logic [2:0]        count_next;
  logic [WORD_W-1:0] word_next;
  logic              complete;
  logic [DATA_W-1:0] padded;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign block      = (mode == MODE_DECODE) ? DEC_BLOCK : ENC_BLOCK;
  assign word_next  = {gathered_word[WORD_W-9:0], in_item.data_byte};
  assign count_next = byte_count + 3'd1;
  assign complete   = (count_next == block);

  // zero-pad a partial encode block at the low end
  always_comb begin
    case (byte_count)
      3'd1:    padded = {gathered_word[7:0], 24'h0};
      3'd2:    padded = {gathered_word[15:0], 16'h0};
      3'd3:    padded = {gathered_word[23:0], 8'h0};
      default: padded = gathered_word[DATA_W-1:0];
    endcase
  end

  // job building
  always_comb begin
    push_job = '{word: '0, nbytes: 3'd0, status: ST_DATA};
    push     = 1'b0;
    if (in_item.operation == OP_DATA) begin
      push = accept && complete;
      if (mode == MODE_DECODE) begin
        push_job.word   = {decode_word(word_next), 8'h0};
        push_job.nbytes = 3'd4;
      end else begin
        push_job.word   = encode_word(word_next[DATA_W-1:0]);
        push_job.nbytes = 3'd5;
      end
    end else begin
      push = accept;
      if (mode == MODE_DECODE) begin
        push_job.status = (gathered_word != '0) ? ST_BAD_WORD : ST_END_OK;
      end else begin
        push_job.status = ST_END_OK;
        if (padded != '0) begin
          push_job.word   = encode_word(padded);
          push_job.nbytes = 3'd5;
        end
      end
    end
  end

  // mode register and gathering state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_ENCODE;
      byte_count    <= 3'd0;
      gathered_word <= '0;
    end else if (cfg_we) begin
      mode          <= cfg_data;
      byte_count    <= 3'd0;
      gathered_word <= '0;
    end else if (accept) begin
      if (in_item.operation == OP_END || complete) begin
        byte_count    <= 3'd0;
        gathered_word <= '0;
      end else begin
        byte_count    <= count_next;
        gathered_word <= word_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hbc_queue.sv -----
// short job queue between the front and back ends
`default_nettype none

module hbc_queue
  import hbc_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      q_valid,
  output logic      q_full,
  output job_t      q_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_valid = (count != '0);
  assign q_full  = (count == CNT_W'(DEPTH));
  assign q_job   = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hbc_back.sv -----
// back end: plays a job out as result items, one per cycle while out_ready is high
`default_nettype none

module hbc_back
  import hbc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_item
);

  logic              cur_valid;
  logic [WORD_W-1:0] word;
  logic [2:0]        bytes_left;
  logic [1:0]        status;

  logic is_last;
  logic take;

  assign is_last   = (bytes_left == 3'd0) || (bytes_left == 3'd1 && status == ST_DATA);
  assign take      = !cur_valid || (out_ready && is_last);
  assign pop       = take && q_valid;
  assign out_valid = cur_valid;

  // current result item
  always_comb begin
    if (bytes_left != 3'd0) begin
      out_item = '{out_byte: word[WORD_W-1:WORD_W-8], status: ST_DATA,
                   last_of_run: is_last};
    end else begin
      out_item = '{out_byte: 8'h0, status: status, last_of_run: 1'b1};
    end
  end

  // job register and byte shifter
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (take) begin
      cur_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word       <= q_job.word;
      bytes_left <= q_job.nbytes;
      status     <= q_job.status;
    end else if (out_ready && bytes_left != 3'd0) begin
      word       <= {word[WORD_W-9:0], 8'h0};
      bytes_left <= bytes_left - 3'd1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/hamming_byte_stream_codec.sv -----
// top level of the byte-stream hamming (38,32) codec
`default_nettype none

// Byte-stream Hamming(38,32) codec. With mode 0 it packs four data bytes into
// a 40-bit codeword sent as five bytes; with mode 1 it takes five codeword
// bytes and returns the four data bytes without checking parity. An end item
// flushes any partial block and yields a status item (1 clean, 2 bad partial
// word in decode). Input items are taken one per cycle while the job queue
// has room; results leave one per cycle while the output is ready, so a
// steady encode stream yields five output bytes per four input bytes and the
// output port sets the pace. Writing the mode register clears any partial
// block. A completed block passes through a queue entry and the job register.
module hamming_byte_stream_codec
  import hbc_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_item
);

  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t q_job;

  // item gathering and job building
  hbc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  // job queue
  hbc_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_valid  (q_valid),
    .q_full   (q_full),
    .q_job    (q_job)
  );

  // result serializer
  hbc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ----- tb/hamming_byte_stream_codec_tb.sv -----
// testbench for the byte-stream hamming codec: directed table then random streams, all checked
module hamming_byte_stream_codec_tb;
  import hbc_pkg::*;

  localparam int PREDICT       = -1;
  localparam int SETTLE_CYCLES = 6;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 50;

  typedef enum logic [1:0] {ROW_DATA, ROW_END, ROW_MODE} row_kind_t;

  // one line of the directed table; n_typed of PREDICT means use the predictor
  typedef struct {
    row_kind_t  kind;
    logic [7:0] value;
    int         n_typed;
    logic [7:0] typed_byte;
    logic [1:0] typed_status;
  } stim_row_t;

  logic      clk      = 1'b0;
  logic      rst      = 1'b1;
  logic      cfg_we   = 1'b0;
  logic      cfg_data = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  // predictor state
  logic        pred_mode  = MODE_ENCODE;
  logic [2:0]  pred_count = '0;
  logic [39:0] pred_word  = '0;

  out_item_t   codec_results[$];
  out_item_t   awaited_results[$];
  stim_row_t   directed_rows[$];
  out_item_t   head_item;
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_hold = 0;
  logic        calm = 1'b0;

  hamming_byte_stream_codec dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // data bits at the non power-of-two positions; each parity bit is one bit of the
  // xor of the indexes of all set data positions
  function automatic logic [39:0] hamming_pack(input logic [31:0] data);
    logic [39:0] cw;
    logic [5:0]  syndrome;
    int          j;
    cw = '0;
    syndrome = '0;
    j = 31;
    for (int p = 1; p <= 38; p++) begin
      if ((p & (p - 1)) != 0) begin
        cw[39 - p] = data[j];
        if (data[j]) syndrome = syndrome ^ 6'(p);
        j--;
      end
    end
    for (int k = 0; k < 6; k++) cw[39 - (1 << k)] = syndrome[k];
    return cw;
  endfunction

  function automatic logic [31:0] hamming_unpack(input logic [39:0] cw);
    logic [31:0] data;
    int          j;
    data = '0;
    j = 31;
    for (int p = 1; p <= 38; p++) begin
      if ((p & (p - 1)) != 0) begin
        data[j] = cw[39 - p];
        j--;
      end
    end
    return data;
  endfunction

  // low nbytes bytes of word, most significant first
  task automatic push_bytes(input logic [39:0] word, input int nbytes);
    out_item_t r;
    for (int i = 0; i < nbytes; i++) begin
      r.out_byte = word[8 * (nbytes - 1 - i) +: 8];
      r.status = ST_DATA;
      r.last_of_run = 1'b0;
      codec_results.push_back(r);
    end
  endtask

  task automatic push_status(input logic [1:0] st);
    out_item_t r;
    r.out_byte = 8'h00;
    r.status = st;
    r.last_of_run = 1'b0;
    codec_results.push_back(r);
  endtask

  // advance the predictor by one accepted item, results land in codec_results
  task automatic codec_predict(input in_item_t it);
    logic [2:0]  blk;
    logic [39:0] padded;
    out_item_t   r;
    codec_results.delete();
    blk = (pred_mode == MODE_DECODE) ? DEC_BLOCK : ENC_BLOCK;
    if (it.operation == OP_DATA) begin
      pred_word = {pred_word[31:0], it.data_byte};
      pred_count = pred_count + 3'd1;
      if (pred_count >= blk) begin
        if (pred_mode == MODE_DECODE) push_bytes({8'h00, hamming_unpack(pred_word)}, 4);
        else push_bytes(hamming_pack(pred_word[31:0]), 5);
        pred_count = '0;
        pred_word = '0;
      end
    end else begin
      padded = pred_word;
      if (pred_count != 0) padded = pred_word << (8 * (blk - pred_count));
      if (pred_mode == MODE_DECODE) begin
        push_status((padded != 0) ? ST_BAD_WORD : ST_END_OK);
      end else begin
        if (padded != 0) push_bytes(hamming_pack(padded[31:0]), 5);
        push_status(ST_END_OK);
      end
      pred_count = '0;
      pred_word = '0;
    end
    if (codec_results.size() > 0) begin
      r = codec_results.pop_back();
      r.last_of_run = 1'b1;
      codec_results.push_back(r);
    end
  endtask

  // offer one item, maybe after a random gap, and record what it should produce
  task automatic send_item(input in_item_t it, input int n_typed,
                           input logic [7:0] typed_byte, input logic [1:0] typed_status);
    int unsigned gap;
    out_item_t   r;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    codec_predict(it);
    if (n_typed == PREDICT) begin
      foreach (codec_results[i]) awaited_results.push_back(codec_results[i]);
    end else begin
      for (int i = 0; i < n_typed; i++) begin
        r.out_byte = typed_byte;
        r.status = typed_status;
        r.last_of_run = (i == n_typed - 1);
        awaited_results.push_back(r);
      end
    end
  endtask

  // stop offering items until every awaited result is out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_we <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    pred_mode = m;
    pred_count = '0;
    pred_word = '0;
  endtask

  task automatic add_row(input row_kind_t kind, input logic [7:0] value, input int n_typed,
                         input logic [7:0] typed_byte, input logic [1:0] typed_status);
    stim_row_t row;
    row.kind = kind;
    row.value = value;
    row.n_typed = n_typed;
    row.typed_byte = typed_byte;
    row.typed_status = typed_status;
    directed_rows.push_back(row);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // receiver: random ready runs and stall bursts, always ready once calm
  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (out_ready && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      ready_hold <= $urandom_range(0, 10);
    end else begin
      out_ready <= 1'b1;
      ready_hold <= $urandom_range(0, 20);
    end
  end

  // compare each result with the oldest awaited one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_results.size() == 0) begin
        flag_failure($sformatf("unexpected result: byte %h status %0d last %b",
                               out_item.out_byte, out_item.status, out_item.last_of_run));
      end else begin
        head_item = awaited_results.pop_front();
        if (out_item.out_byte !== head_item.out_byte || out_item.status !== head_item.status ||
            out_item.last_of_run !== head_item.last_of_run)
          flag_failure($sformatf(
            "mismatch: expected byte %h status %0d last %b, got byte %h status %0d last %b",
            head_item.out_byte, head_item.status, head_item.last_of_run,
            out_item.out_byte, out_item.status, out_item.last_of_run));
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_item_t    it;
    stim_row_t   row;
    int unsigned phase_items;
    int          blk;
    int          nblk;
    int          npart;

    // encode mode after reset
    add_row(ROW_END,  8'h00, 1, 8'h00, ST_END_OK);   // end of an empty stream
    add_row(ROW_DATA, 8'h00, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'h00, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'h00, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'h00, 5, 8'h00, ST_DATA);     // zero word gives zero codeword
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'h80, PREDICT, 8'h00, ST_DATA);  // nonzero partial block, padded
    add_row(ROW_END,  8'h00, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'h00, PREDICT, 8'h00, ST_DATA);  // zero partial block, status only
    add_row(ROW_END,  8'h00, 1, 8'h00, ST_END_OK);
    add_row(ROW_DATA, 8'ha5, PREDICT, 8'h00, ST_DATA);  // left partial across the mode write
    add_row(ROW_DATA, 8'h5a, PREDICT, 8'h00, ST_DATA);
    // decode mode
    add_row(ROW_MODE, 8'h01, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_END,  8'h00, 1, 8'h00, ST_END_OK);   // mode write dropped the partial block
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_DATA, 8'hff, 4, 8'hff, ST_DATA);     // all-ones codeword, all-ones data
    add_row(ROW_DATA, 8'h01, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_END,  8'h00, 1, 8'h00, ST_BAD_WORD); // nonzero partial codeword
    add_row(ROW_DATA, 8'h00, PREDICT, 8'h00, ST_DATA);
    add_row(ROW_END,  8'h00, 1, 8'h00, ST_END_OK);   // zero partial codeword is clean
    add_row(ROW_MODE, 8'h00, PREDICT, 8'h00, ST_DATA);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_MODE) begin
        settle();
        write_mode(row.value[0]);
      end else begin
        it.operation = (row.kind == ROW_END) ? OP_END : OP_DATA;
        it.data_byte = row.value;
        send_item(it, row.n_typed, row.typed_byte, row.typed_status);
      end
    end

    // random phases, each under one mode setting; the last one runs without idling
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if (ph == PHASES - 1) calm = 1'b1;
      if (ph == 0) write_mode(MODE_DECODE);
      else if (ph == 1) write_mode(MODE_ENCODE);
      else write_mode(1'($urandom_range(0, 1)));
      blk = (pred_mode == MODE_DECODE) ? 5 : 4;
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        if (!calm && $urandom_range(0, 9) == 0) settle();
        if ($urandom_range(0, 7) == 0) begin
          // noise item
          it.operation = 1'($urandom_range(0, 1));
          it.data_byte = 8'($urandom);
          send_item(it, PREDICT, 8'h00, ST_DATA);
          phase_items++;
        end else begin
          // stream: full blocks, a partial tail, usually an end
          nblk = $urandom_range(0, 3);
          npart = $urandom_range(0, blk - 1);
          repeat (nblk * blk + npart) begin
            it.operation = OP_DATA;
            it.data_byte = pick_byte();
            send_item(it, PREDICT, 8'h00, ST_DATA);
            phase_items++;
          end
          if ($urandom_range(0, 7) != 0) begin
            it.operation = OP_END;
            it.data_byte = 8'($urandom);
            send_item(it, PREDICT, 8'h00, ST_DATA);
            phase_items++;
          end
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/hbc_pkg.sv
rtl/hbc_front.sv
rtl/hbc_queue.sv
rtl/hbc_back.sv
rtl/hamming_byte_stream_codec.sv
tb/hamming_byte_stream_codec_tb.sv
